/* hdl/crc_checked_frame_parser_defines.svh */
// ---------------------------------------------------------------------------
// crc_checked_frame_parser_defines: assertion macros
// Shared macros for the concurrent checks of the frame parser.
// ---------------------------------------------------------------------------
`ifndef CRC_CHECKED_FRAME_PARSER_DEFINES_SVH
`define CRC_CHECKED_FRAME_PARSER_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define CFP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define CFP_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

/* hdl/cfp_pkg.sv */
// ---------------------------------------------------------------------------
// cfp_pkg: shared types and constants of the frame parser
// Phase and result-kind codes, header positions, result struct, CRC step.
// ---------------------------------------------------------------------------
`default_nettype none

package cfp_pkg;

    localparam int          MAX_PAYLOAD      = 256;
    localparam int          LEN_W            = 9;
    localparam int          TDATA_W          = 48;
    localparam logic [7:0]  START_BYTE_RESET = 8'hAA;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    // Header byte positions
    localparam logic [LEN_W-1:0] HDR_CMD    = LEN_W'(0);
    localparam logic [LEN_W-1:0] HDR_SEQ_HI = LEN_W'(1);
    localparam logic [LEN_W-1:0] HDR_SEQ_LO = LEN_W'(2);
    localparam logic [LEN_W-1:0] HDR_LEN_HI = LEN_W'(3);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CRC_HI,
        PH_CRC_LO
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_GOOD,
        KIND_BAD
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic [15:0]      seq;
        logic [7:0]       cmd;
    } result_t;

    // One byte of CRC-16/CCITT, MSB first, no reflection
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hdl/cfp_parser.sv */
// ---------------------------------------------------------------------------
// cfp_parser: frame state machine and running CRC
// Consumes one byte per accepted transfer and produces at most one result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "crc_checked_frame_parser_defines.svh"

module cfp_parser (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_fire,
    input  wire logic [7:0]          cfg_byte,
    input  wire logic                in_fire,
    input  wire logic [7:0]          in_byte,
    output logic                     res_valid,
    output cfp_pkg::result_t         res
);

    cfp_pkg::phase_t                 phase_reg, phase_next;
    logic [cfp_pkg::LEN_W-1:0]       idx_reg, idx_next;
    logic [cfp_pkg::LEN_W-1:0]       len_reg, len_next;
    logic [7:0]                      len_hi_reg, len_hi_next;
    logic [7:0]                      cmd_reg, cmd_next;
    logic [15:0]                     seq_reg, seq_next;
    logic [15:0]                     crc_reg, crc_next;
    logic [7:0]                      crc_hi_reg, crc_hi_next;
    logic [7:0]                      start_reg;
    logic [cfp_pkg::LEN_W-1:0]       idx_inc;
    logic [15:0]                     len_full;
    logic [15:0]                     crc_upd;

    // Hold the start byte register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= cfp_pkg::START_BYTE_RESET;
        end else if (cfg_fire) begin
            start_reg <= cfg_byte;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= cfp_pkg::PH_HUNT;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // Frame fields and CRC
    always_ff @(posedge aclk) begin
        len_reg    <= len_next;
        len_hi_reg <= len_hi_next;
        cmd_reg    <= cmd_next;
        seq_reg    <= seq_next;
        crc_reg    <= crc_next;
        crc_hi_reg <= crc_hi_next;
    end

    assign idx_inc  = idx_reg + cfp_pkg::LEN_W'(1);
    assign len_full = {len_hi_reg, in_byte};
    assign crc_upd  = cfp_pkg::crc_add_byte(crc_reg, in_byte);

    // Next state and result
    always_comb begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        len_hi_next = len_hi_reg;
        cmd_next    = cmd_reg;
        seq_next    = seq_reg;
        crc_next    = crc_reg;
        crc_hi_next = crc_hi_reg;
        res_valid   = 1'b0;
        res.kind    = cfp_pkg::KIND_DATA;
        res.data    = in_byte;
        res.len     = len_reg;
        res.seq     = seq_reg;
        res.cmd     = cmd_reg;
        if (in_fire) begin
            case (phase_reg)
                cfp_pkg::PH_HUNT: begin
                    if (in_byte == start_reg) begin
                        phase_next = cfp_pkg::PH_HEADER;
                        idx_next   = '0;
                        crc_next   = cfp_pkg::CRC_INIT;
                    end
                end
                cfp_pkg::PH_HEADER: begin
                    crc_next = crc_upd;
                    idx_next = idx_inc;
                    case (idx_reg)
                        cfp_pkg::HDR_CMD:    cmd_next    = in_byte;
                        cfp_pkg::HDR_SEQ_HI: seq_next    = {in_byte, 8'h00};
                        cfp_pkg::HDR_SEQ_LO: seq_next    = {seq_reg[15:8], in_byte};
                        cfp_pkg::HDR_LEN_HI: len_hi_next = in_byte;
                        default: begin
                            // Last header byte: check length, drop oversize frames
                            idx_next = '0;
                            if (len_full > 16'(cfp_pkg::MAX_PAYLOAD)) begin
                                phase_next = cfp_pkg::PH_HUNT;
                                len_next   = '0;
                            end else begin
                                len_next   = len_full[cfp_pkg::LEN_W-1:0];
                                phase_next = (len_full == 16'h0000) ? cfp_pkg::PH_CRC_HI
                                                                    : cfp_pkg::PH_PAYLOAD;
                            end
                        end
                    endcase
                end
                cfp_pkg::PH_PAYLOAD: begin
                    crc_next  = crc_upd;
                    res_valid = 1'b1;
                    idx_next  = idx_inc;
                    if (idx_inc >= len_reg) begin
                        idx_next   = '0;
                        phase_next = cfp_pkg::PH_CRC_HI;
                    end
                end
                cfp_pkg::PH_CRC_HI: begin
                    crc_hi_next = in_byte;
                    phase_next  = cfp_pkg::PH_CRC_LO;
                end
                cfp_pkg::PH_CRC_LO: begin
                    res_valid  = 1'b1;
                    res.data   = 8'h00;
                    res.kind   = ({crc_hi_reg, in_byte} == crc_reg) ? cfp_pkg::KIND_GOOD
                                                                    : cfp_pkg::KIND_BAD;
                    phase_next = cfp_pkg::PH_HUNT;
                    idx_next   = '0;
                    len_next   = '0;
                end
                default: begin
                    phase_next = cfp_pkg::PH_HUNT;
                    idx_next   = '0;
                    len_next   = '0;
                end
            endcase
        end
    end

    `CFP_ASSERT(a_res_phase, res_valid |-> (phase_reg == cfp_pkg::PH_PAYLOAD || phase_reg == cfp_pkg::PH_CRC_LO), "result outside payload or trailer")
    `CFP_ASSERT(a_verdict_hunt, (in_fire && phase_reg == cfp_pkg::PH_CRC_LO) |=> (phase_reg == cfp_pkg::PH_HUNT && idx_reg == '0), "no return to hunt after verdict")
    `CFP_ASSERT(a_payload_idx, (phase_reg == cfp_pkg::PH_PAYLOAD) |-> (idx_reg < len_reg), "payload index past length")
    `CFP_ASSERT(a_header_idx, (phase_reg == cfp_pkg::PH_HEADER) |-> (idx_reg <= cfp_pkg::LEN_W'(4)), "header index out of range")

endmodule

`default_nettype wire

/* hdl/cfp_out_buf.sv */
// ---------------------------------------------------------------------------
// cfp_out_buf: two-entry result buffer
// Parts the parser from the result channel so input keeps flowing while
// one result waits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "crc_checked_frame_parser_defines.svh"

module cfp_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire cfp_pkg::result_t push_res,
    output logic                  has_room,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cfp_pkg::result_t      out_res
);

    cfp_pkg::result_t ent_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_res   = ent_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed result
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_res;
        end
    end

    `CFP_NEVER(a_count_range, count_reg == 2'd3, "fill count out of range")
    `CFP_NEVER(a_no_overflow, push && !has_room, "push into full buffer")
    `CFP_ASSERT(a_pop_only, (pop && !push) |=> (count_reg == $past(count_reg) - 2'd1), "fill count not decremented")
    `CFP_ASSERT(a_ptr_gap, (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg), "pointers disagree with count")

endmodule

`default_nettype wire

/* hdl/crc_checked_frame_parser.sv */
// ---------------------------------------------------------------------------
// crc_checked_frame_parser: start/length framed packet receiver, CRC-16 check
// Hunts for the start byte, reads the header, passes payload bytes out and
// reports a good frame or a CRC mismatch after the two trailing bytes.
//
//   channel   direction  payload
//   s_*       in         tdata[7:0] rx_byte
//   m_*       out        tuser[1:0] kind, tdata cmd/seq/len/data_byte
//   cfg_*     in         cfg_data[7:0] start_byte
//
// One byte per cycle sustained while s_tready is high; each byte is decoded in
// the cycle that ends with its accepting edge, its result enters the output
// buffer at that edge and is offered on m_* from the next cycle.
// A two-entry output buffer sets the input ready: s_tready is low while two
// results wait in the buffer, which only happens after m_tready has stalled.
// Reset (aresetn low, synchronous) returns the parser to hunting and sets
// start_byte to 0xAA. cfg_ready is always high.
// ---------------------------------------------------------------------------
`default_nettype none

module crc_checked_frame_parser (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // [7:0] frame_cmd, [23:8] frame_seq, [32:24] frame_len, [40:33] data_byte, rest zero
    output logic [cfp_pkg::TDATA_W-1:0]      m_tdata,
    output logic [1:0]                       m_tuser,   // [1:0] kind
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [7:0]                  cfg_data   // [7:0] start_byte
);

    logic             in_fire;
    logic             cfg_fire;
    logic             res_valid;
    logic             has_room;
    cfp_pkg::result_t res;
    cfp_pkg::result_t out_res;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = has_room;
    assign in_fire   = s_tvalid && s_tready;

    cfp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_fire),
        .cfg_byte  (cfg_data),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    cfp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_res  (res),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the result fields, lowest field first
    assign m_tdata = {7'b0, out_res.data, out_res.len, out_res.seq, out_res.cmd};
    assign m_tuser = out_res.kind;

endmodule

`default_nettype wire

/* dv/tb_crc_checked_frame_parser.sv */
// ---------------------------------------------------------------------------
// tb_crc_checked_frame_parser: self-checking testbench of the frame parser
// Drives received bytes through the input stream, predicts each payload
// transfer and each frame verdict with a cycle-free model of the parser and
// checks every output transfer field by field. Covers directed corner frames,
// random well-formed, corrupted, cut and oversized frames, line noise, several
// start byte settings, random stalls on both sides and one long output stall.
// ---------------------------------------------------------------------------

module tb_crc_checked_frame_parser;

    localparam int N_ITEMS       = 700;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 80;
    localparam int TIMEOUT       = 2_000_000;

    // Frame defects injected by the frame builder
    localparam int FLAW_NONE = 0;
    localparam int FLAW_CRC  = 1;
    localparam int FLAW_CUT  = 2;

    // -----------------------------------------------------------------------
    // Parser predictor and store of expected output transfers
    // -----------------------------------------------------------------------
    class frame_scoreboard;
        logic [7:0]        start_byte;
        cfp_pkg::phase_t   phase;
        logic [15:0]       byte_cnt;
        logic [7:0]        cmd;
        logic [15:0]       seq;
        logic [15:0]       len;
        logic [15:0]       crc;
        logic [7:0]        crc_hi;
        cfp_pkg::result_t  expected_q[$];
        int                n_errors;

        function new();
            start_byte = cfp_pkg::START_BYTE_RESET;
            phase      = cfp_pkg::PH_HUNT;
            byte_cnt   = '0;
            cmd        = '0;
            seq        = '0;
            len        = '0;
            crc        = cfp_pkg::CRC_INIT;
            crc_hi     = '0;
            n_errors   = 0;
        endfunction

        // Shift one byte into the CRC, one bit at a time, MSB first
        function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
            logic fb;
            for (int k = 7; k >= 0; k--) begin
                fb = c[15] ^ b[k];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ cfp_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        function void go_hunt();
            phase    = cfp_pkg::PH_HUNT;
            byte_cnt = '0;
            len      = '0;
        endfunction

        function void push_result(input cfp_pkg::kind_t k, input logic [7:0] d);
            cfp_pkg::result_t r;
            r.kind = k;
            r.data = d;
            r.len  = len[cfp_pkg::LEN_W-1:0];
            r.seq  = seq;
            r.cmd  = cmd;
            expected_q.push_back(r);
        endfunction

        // Advance the parser by one accepted byte
        function void note_input(input logic [7:0] b);
            case (phase)
                cfp_pkg::PH_HUNT: begin
                    if (b == start_byte) begin
                        phase    = cfp_pkg::PH_HEADER;
                        byte_cnt = '0;
                        crc      = cfp_pkg::CRC_INIT;
                    end
                end
                cfp_pkg::PH_HEADER: begin
                    crc = crc_step(crc, b);
                    if (byte_cnt == cfp_pkg::HDR_CMD) begin
                        cmd = b;
                    end else if (byte_cnt == cfp_pkg::HDR_SEQ_HI) begin
                        seq = {b, 8'h00};
                    end else if (byte_cnt == cfp_pkg::HDR_SEQ_LO) begin
                        seq[7:0] = b;
                    end else if (byte_cnt == cfp_pkg::HDR_LEN_HI) begin
                        len = {b, 8'h00};
                    end else begin
                        len[7:0] = b;
                    end
                    if (byte_cnt > cfp_pkg::HDR_LEN_HI) begin
                        // last header byte: drop oversize frames
                        if (len > cfp_pkg::MAX_PAYLOAD) begin
                            go_hunt();
                        end else begin
                            byte_cnt = '0;
                            phase    = (len == 0) ? cfp_pkg::PH_CRC_HI
                                                  : cfp_pkg::PH_PAYLOAD;
                        end
                    end else begin
                        byte_cnt++;
                    end
                end
                cfp_pkg::PH_PAYLOAD: begin
                    crc = crc_step(crc, b);
                    push_result(cfp_pkg::KIND_DATA, b);
                    byte_cnt++;
                    if (byte_cnt >= len) begin
                        byte_cnt = '0;
                        phase    = cfp_pkg::PH_CRC_HI;
                    end
                end
                cfp_pkg::PH_CRC_HI: begin
                    crc_hi = b;
                    phase  = cfp_pkg::PH_CRC_LO;
                end
                cfp_pkg::PH_CRC_LO: begin
                    push_result(({crc_hi, b} == crc) ? cfp_pkg::KIND_GOOD
                                                     : cfp_pkg::KIND_BAD, 8'h00);
                    go_hunt();
                end
                default: begin
                    go_hunt();
                end
            endcase
        endfunction

        task report(input string field, input int unsigned want_v, input int unsigned got_v);
            $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, field, want_v, got_v);
            n_errors++;
        endtask

        // Compare one output transfer with the oldest expectation
        task check_result(input logic [1:0] kind,
                          input logic [cfp_pkg::TDATA_W-1:0] tdata);
            cfp_pkg::result_t want;
            if (expected_q.size() == 0) begin
                report("unexpected transfer kind", 0, kind);
            end else begin
                want = expected_q.pop_front();
                if (kind !== want.kind)          report("kind", want.kind, kind);
                if (tdata[7:0] !== want.cmd)     report("frame_cmd", want.cmd, tdata[7:0]);
                if (tdata[23:8] !== want.seq)    report("frame_seq", want.seq, tdata[23:8]);
                if (tdata[32:24] !== want.len)   report("frame_len", want.len, tdata[32:24]);
                if (tdata[40:33] !== want.data)  report("data_byte", want.data, tdata[40:33]);
            end
        endtask
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [7:0]                    s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [cfp_pkg::TDATA_W-1:0]   m_tdata;
    logic [1:0]                    m_tuser;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [7:0]                    cfg_data;

    frame_scoreboard sb;
    logic [7:0]      cur_start = cfp_pkg::START_BYTE_RESET;
    int              n_sent = 0;
    bit              no_idle = 1'b0;
    int              hold_request = 0;

    crc_checked_frame_parser u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Stimulus tasks
    // -----------------------------------------------------------------------

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b);
        n_sent++;
    endtask

    // Build a frame with random payload, optionally damaged, and send it
    task automatic drive_frame(input logic [7:0] cmd, input logic [15:0] seq,
                               input logic [15:0] len, input int flaw);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        int          cut;
        frame_bytes.push_back(cur_start);
        frame_bytes.push_back(cmd);
        frame_bytes.push_back(seq[15:8]);
        frame_bytes.push_back(seq[7:0]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        // oversize frames end after the header
        if (len <= cfp_pkg::MAX_PAYLOAD) begin
            repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
            crc = cfp_pkg::CRC_INIT;
            for (int i = 1; i < frame_bytes.size(); i++) begin
                crc = sb.crc_step(crc, frame_bytes[i]);
            end
            if (flaw == FLAW_CRC) begin
                crc = crc ^ (16'h0001 << $urandom_range(0, 15));
            end
            frame_bytes.push_back(crc[15:8]);
            frame_bytes.push_back(crc[7:0]);
        end
        cut = frame_bytes.size();
        if (flaw == FLAW_CUT) begin
            cut = $urandom_range(1, frame_bytes.size() - 1);
        end
        for (int i = 0; i < cut; i++) begin
            send_byte(frame_bytes[i]);
        end
    endtask

    // Mostly short payloads, a few long ones
    function automatic logic [15:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return 16'($urandom_range(0, 8));
        end else if (r < 97) begin
            return 16'($urandom_range(9, 40));
        end
        return 16'($urandom_range(41, cfp_pkg::MAX_PAYLOAD));
    endfunction

    function automatic logic [15:0] pick_oversize_len();
        case ($urandom_range(0, 2))
            0:       return 16'(cfp_pkg::MAX_PAYLOAD + 1);
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(cfp_pkg::MAX_PAYLOAD + 1, 65535));
        endcase
    endfunction

    // Mix of frames and noise until the byte count reaches the target
    task automatic random_traffic(input int target);
        int pick;
        logic [7:0]  cmd;
        logic [15:0] seq;
        while (n_sent < target) begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick    = $urandom_range(0, 99);
            cmd     = 8'($urandom_range(0, 255));
            seq     = 16'($urandom_range(0, 65535));
            if (pick < 70) begin
                drive_frame(cmd, seq, pick_len(), FLAW_NONE);
            end else if (pick < 80) begin
                drive_frame(cmd, seq, pick_len(), FLAW_CRC);
            end else if (pick < 87) begin
                drive_frame(cmd, seq, pick_oversize_len(), FLAW_NONE);
            end else if (pick < 93) begin
                drive_frame(cmd, seq, pick_len(), FLAW_CUT);
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
        no_idle = 1'b0;
    endtask

    // Drain all expected transfers, then let the parser settle
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_start(input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.start_byte = value;
        cur_start     = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Output side: random stalls, one long hold-off on request
    // -----------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tuser, m_tdata);
        end
    end

    // -----------------------------------------------------------------------
    // Test sequence
    // -----------------------------------------------------------------------
    initial begin : main_seq
        sb        = new();
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: noise while hunting, empty frame, bad CRC, oversize length
        send_byte(8'h00);
        send_byte(8'hFF);
        drive_frame(8'hFF, 16'hFFFF, 16'h0000, FLAW_NONE);
        drive_frame(8'h00, 16'h0000, 16'h0001, FLAW_CRC);
        drive_frame(8'h12, 16'h3456, 16'(cfp_pkg::MAX_PAYLOAD + 1), FLAW_NONE);

        wait_idle();
        write_start(8'h00);
        random_traffic(200);

        // Full-size frame against a long output stall to back up the input
        wait_idle();
        write_start(8'hFF);
        while (sb.phase != cfp_pkg::PH_HUNT) send_byte(8'h00);
        hold_request = LONG_HOLD;
        drive_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                    16'(cfp_pkg::MAX_PAYLOAD), FLAW_NONE);
        random_traffic(550);

        wait_idle();
        write_start(8'($urandom_range(1, 254)));
        random_traffic(630);

        wait_idle();
        write_start(cfp_pkg::START_BYTE_RESET);
        random_traffic(N_ITEMS);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
            $display("[crc_checked_frame_parser] OK");
        end else begin
            $display("[crc_checked_frame_parser] ERROR");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin : watchdog
        #TIMEOUT;
        $display("[crc_checked_frame_parser] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/cfp_pkg.sv
hdl/cfp_parser.sv
hdl/cfp_out_buf.sv
hdl/crc_checked_frame_parser.sv
dv/tb_crc_checked_frame_parser.sv
